// ===== sv/tlex_pkg.sv =====
// tlex_pkg: types, codes and character-class helpers shared by the lexer modules
`default_nettype none
package tlex_pkg;

  typedef enum logic [2:0] {
    MODE_IDLE   = 3'd0,
    MODE_IDENT  = 3'd1,
    MODE_HEADER = 3'd2,
    MODE_NUMBER = 3'd3,
    MODE_STRING = 3'd4
  } mode_t;

  localparam logic [1:0] KIND_TEXT = 2'd0;
  localparam logic [1:0] KIND_END  = 2'd1;
  localparam logic [1:0] KIND_EOF  = 2'd2;

  localparam logic [4:0] TYPE_UNKNOWN = 5'd0;
  localparam logic [4:0] TYPE_IDENT   = 5'd1;
  localparam logic [4:0] TYPE_NUMBER  = 5'd2;
  localparam logic [4:0] TYPE_STRING  = 5'd3;
  localparam logic [4:0] TYPE_INVALID = 5'd4;
  localparam logic [4:0] TYPE_EQUAL   = 5'd5;
  localparam logic [4:0] TYPE_COLON   = 5'd6;
  localparam logic [4:0] TYPE_AT      = 5'd7;
  localparam logic [4:0] TYPE_DOT     = 5'd8;
  localparam logic [4:0] TYPE_COMMA   = 5'd9;
  localparam logic [4:0] TYPE_BANG    = 5'd10;
  localparam logic [4:0] TYPE_SEMI    = 5'd11;
  localparam logic [4:0] TYPE_LBRACK  = 5'd12;
  localparam logic [4:0] TYPE_RBRACK  = 5'd13;
  localparam logic [4:0] TYPE_LBRACE  = 5'd14;
  localparam logic [4:0] TYPE_RBRACE  = 5'd15;
  localparam logic [4:0] TYPE_SLASH   = 5'd16;
  localparam logic [4:0] TYPE_HEADER  = 5'd17;
  localparam logic [4:0] TYPE_LESS    = 5'd18;
  localparam logic [4:0] TYPE_GREATER = 5'd19;
  localparam logic [4:0] TYPE_EOF     = 5'd20;

  // keyword tracker codes
  localparam logic [1:0] KW_NONE  = 2'd0;
  localparam logic [1:0] KW_TRUE  = 2'd1;
  localparam logic [1:0] KW_FALSE = 2'd2;

  localparam logic [7:0] MAX_LEN_RESET = 8'd255;

  // one result record
  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] text_char;
    logic [4:0] token_type;
    logic [7:0] token_length;
    logic       truncated;
  } res_t;

  // all results of one input beat, slot 0 first
  typedef struct packed {
    logic [1:0]      cnt;
    res_t [2:0]      rec;
  } bundle_t;

  // bundle handed over with its valid flag
  typedef struct packed {
    logic    valid;
    bundle_t data;
  } bundle_chan_t;

  function automatic logic is_space(input logic [7:0] c);
    return c == 8'h20 || c == 8'h09 || c == 8'h0B || c == 8'h0C;
  endfunction

  function automatic logic is_line_end(input logic [7:0] c);
    return c == 8'h0A || c == 8'h0D;
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return c >= 8'h30 && c <= 8'h39;
  endfunction

  function automatic logic is_alpha(input logic [7:0] c);
    return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A) || c == 8'h5F;
  endfunction

  function automatic logic is_alnum(input logic [7:0] c);
    return is_alpha(c) || is_digit(c);
  endfunction

  function automatic logic [4:0] punct_type(input logic [7:0] c);
    logic [4:0] p;
    p = TYPE_UNKNOWN;
    case (c)
      8'h3D:   p = TYPE_EQUAL;
      8'h3A:   p = TYPE_COLON;
      8'h40:   p = TYPE_AT;
      8'h2E:   p = TYPE_DOT;
      8'h2C:   p = TYPE_COMMA;
      8'h21:   p = TYPE_BANG;
      8'h3B:   p = TYPE_SEMI;
      8'h5B:   p = TYPE_LBRACK;
      8'h5D:   p = TYPE_RBRACK;
      8'h7B:   p = TYPE_LBRACE;
      8'h7D:   p = TYPE_RBRACE;
      8'h2F:   p = TYPE_SLASH;
      8'h5C:   p = TYPE_SLASH;
      8'h3C:   p = TYPE_LESS;
      8'h3E:   p = TYPE_GREATER;
      default: p = TYPE_UNKNOWN;
    endcase
    return p;
  endfunction

  function automatic logic [7:0] kw_len(input logic [1:0] kw);
    logic [7:0] l;
    case (kw)
      KW_TRUE:  l = 8'd4;
      KW_FALSE: l = 8'd5;
      default:  l = 8'd0;
    endcase
    return l;
  endfunction

  // expected keyword character at a position; only read below kw_len
  function automatic logic [7:0] kw_char(input logic [1:0] kw, input logic [7:0] idx);
    logic [7:0] ch;
    ch = 8'h00;
    if (kw == KW_TRUE) begin
      case (idx)
        8'd0:    ch = 8'h74;
        8'd1:    ch = 8'h72;
        8'd2:    ch = 8'h75;
        8'd3:    ch = 8'h65;
        default: ch = 8'h00;
      endcase
    end else if (kw == KW_FALSE) begin
      case (idx)
        8'd0:    ch = 8'h66;
        8'd1:    ch = 8'h61;
        8'd2:    ch = 8'h6C;
        8'd3:    ch = 8'h73;
        8'd4:    ch = 8'h65;
        default: ch = 8'h00;
      endcase
    end
    return ch;
  endfunction

  function automatic res_t text_rec(input logic [7:0] c);
    res_t r;
    r.kind         = KIND_TEXT;
    r.text_char    = c;
    r.token_type   = TYPE_UNKNOWN;
    r.token_length = 8'd0;
    r.truncated    = 1'b0;
    return r;
  endfunction

  function automatic res_t end_rec(input logic [1:0] kind, input logic [4:0] typ,
                                   input logic [7:0] len, input logic trunc);
    res_t r;
    r.kind         = kind;
    r.text_char    = 8'd0;
    r.token_type   = typ;
    r.token_length = len;
    r.truncated    = trunc;
    return r;
  endfunction

endpackage
`default_nettype wire

// ===== sv/tlex_front.sv =====
// tlex_front: token state machine, turns one character beat into a bundle of results
`default_nettype none
module tlex_front (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  accept,
  input  wire logic [7:0]            ch,
  input  wire logic                  end_of_stream,
  input  wire logic                  cfg_wr_en,
  input  wire logic [7:0]            cfg_wr_data,
  output tlex_pkg::bundle_chan_t     push
);

  tlex_pkg::mode_t mode_r, mode_nxt;
  logic            point_r, point_nxt;
  logic [7:0]      cnt_r, cnt_nxt;
  logic [1:0]      kw_r, kw_nxt;
  logic            ovf_r, ovf_nxt;
  logic [7:0]      max_len_r;

  logic            cont, end_now, do_start, emit_c, start_tok;
  logic [4:0]      end_type, p_type;
  logic [1:0]      n;
  tlex_pkg::res_t [2:0] recs;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r    <= tlex_pkg::MODE_IDLE;
      point_r   <= 1'b0;
      cnt_r     <= 8'd0;
      kw_r      <= tlex_pkg::KW_NONE;
      ovf_r     <= 1'b0;
      max_len_r <= tlex_pkg::MAX_LEN_RESET;
    end else begin
      mode_r  <= mode_nxt;
      point_r <= point_nxt;
      cnt_r   <= cnt_nxt;
      kw_r    <= kw_nxt;
      ovf_r   <= ovf_nxt;
      if (cfg_wr_en) begin
        max_len_r <= cfg_wr_data;
      end
    end
  end

  always_comb begin
    mode_nxt  = mode_r;
    point_nxt = point_r;
    cnt_nxt   = cnt_r;
    kw_nxt    = kw_r;
    ovf_nxt   = ovf_r;
    n         = 2'd0;
    recs      = '0;
    cont      = 1'b0;
    end_now   = 1'b0;
    do_start  = 1'b0;
    emit_c    = 1'b0;
    start_tok = 1'b0;
    end_type  = tlex_pkg::TYPE_UNKNOWN;
    p_type    = tlex_pkg::punct_type(ch);

    // how the open token reacts to this beat
    unique case (mode_r)
      tlex_pkg::MODE_IDENT: begin
        end_type = ((kw_r == tlex_pkg::KW_TRUE || kw_r == tlex_pkg::KW_FALSE) && !ovf_r &&
                    cnt_r == tlex_pkg::kw_len(kw_r)) ? tlex_pkg::TYPE_NUMBER
                                                     : tlex_pkg::TYPE_IDENT;
        if (end_of_stream) begin
          end_now = 1'b1;
        end else if (tlex_pkg::is_alnum(ch)) begin
          cont = 1'b1;
        end else begin
          end_now  = 1'b1;
          do_start = 1'b1;
        end
      end
      tlex_pkg::MODE_HEADER: begin
        end_type = tlex_pkg::TYPE_HEADER;
        if (end_of_stream) begin
          end_now = 1'b1;
        end else if (tlex_pkg::is_alnum(ch)) begin
          cont = 1'b1;
        end else begin
          end_now  = 1'b1;
          do_start = 1'b1;
        end
      end
      tlex_pkg::MODE_NUMBER: begin
        end_type = tlex_pkg::TYPE_NUMBER;
        if (end_of_stream) begin
          end_now = 1'b1;
        end else if (tlex_pkg::is_digit(ch) || (ch == 8'h2E && !point_r)) begin
          cont = 1'b1;
        end else begin
          end_now  = 1'b1;
          do_start = 1'b1;
        end
      end
      tlex_pkg::MODE_STRING: begin
        if (end_of_stream) begin
          end_now  = 1'b1;
          end_type = tlex_pkg::TYPE_INVALID;
        end else if (ch == 8'h22) begin
          end_now  = 1'b1;
          end_type = tlex_pkg::TYPE_STRING;
        end else if (tlex_pkg::is_line_end(ch)) begin
          end_now  = 1'b1;
          end_type = tlex_pkg::TYPE_INVALID;
        end else begin
          cont = 1'b1;
        end
      end
      default: begin
        do_start = !end_of_stream;
      end
    endcase

    if (accept) begin
      if (end_now) begin
        recs[n]   = tlex_pkg::end_rec(tlex_pkg::KIND_END, end_type, cnt_r, ovf_r);
        n         = n + 2'd1;
        mode_nxt  = tlex_pkg::MODE_IDLE;
        point_nxt = 1'b0;
        cnt_nxt   = 8'd0;
        kw_nxt    = tlex_pkg::KW_NONE;
        ovf_nxt   = 1'b0;
      end

      if (end_of_stream) begin
        // idle state is always clean, so only the eof record remains
        recs[n] = tlex_pkg::end_rec(tlex_pkg::KIND_EOF, tlex_pkg::TYPE_EOF, 8'd0, 1'b0);
        n       = n + 2'd1;
      end

      // a new token starts on anything but blanks and line ends
      if (do_start && !tlex_pkg::is_space(ch) && !tlex_pkg::is_line_end(ch)) begin
        if (ch == 8'h22) begin
          mode_nxt = tlex_pkg::MODE_STRING;
        end else begin
          start_tok = 1'b1;
          emit_c    = 1'b1;
          if (ch == 8'h74 && max_len_r != 8'd0) begin
            kw_nxt = tlex_pkg::KW_TRUE;
          end else if (ch == 8'h66 && max_len_r != 8'd0) begin
            kw_nxt = tlex_pkg::KW_FALSE;
          end
        end
      end

      if (cont) begin
        emit_c = 1'b1;
        if (mode_r == tlex_pkg::MODE_IDENT) begin
          if (kw_r != tlex_pkg::KW_TRUE && kw_r != tlex_pkg::KW_FALSE) begin
            kw_nxt = tlex_pkg::KW_NONE;
          end else if (ovf_r || cnt_r >= max_len_r || cnt_r >= tlex_pkg::kw_len(kw_r) ||
                       tlex_pkg::kw_char(kw_r, cnt_r) != ch) begin
            kw_nxt = tlex_pkg::KW_NONE;
          end
        end
        if (mode_r == tlex_pkg::MODE_NUMBER && ch == 8'h2E) begin
          point_nxt = 1'b1;
        end
      end

      if (emit_c) begin
        if (cnt_nxt < max_len_r) begin
          recs[n] = tlex_pkg::text_rec(ch);
          n       = n + 2'd1;
          cnt_nxt = cnt_nxt + 8'd1;
        end else begin
          ovf_nxt = 1'b1;
        end
      end

      // classify the start character; single-character tokens close at once
      if (start_tok) begin
        if (ch == 8'h3F) begin
          mode_nxt = tlex_pkg::MODE_HEADER;
        end else if (p_type != tlex_pkg::TYPE_UNKNOWN || !tlex_pkg::is_alnum(ch)) begin
          recs[n]   = tlex_pkg::end_rec(tlex_pkg::KIND_END, p_type, cnt_nxt, ovf_nxt);
          n         = n + 2'd1;
          mode_nxt  = tlex_pkg::MODE_IDLE;
          point_nxt = 1'b0;
          cnt_nxt   = 8'd0;
          kw_nxt    = tlex_pkg::KW_NONE;
          ovf_nxt   = 1'b0;
        end else if (tlex_pkg::is_alpha(ch)) begin
          mode_nxt = tlex_pkg::MODE_IDENT;
        end else begin
          mode_nxt = tlex_pkg::MODE_NUMBER;
        end
      end
    end

    push.valid    = accept && (n != 2'd0);
    push.data.cnt = n;
    push.data.rec = recs;
  end

endmodule
`default_nettype wire

// ===== sv/tlex_fifo.sv =====
// tlex_fifo: short queue of result bundles between the front and the back
`default_nettype none
module tlex_fifo #(
  parameter int Depth = 4
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire tlex_pkg::bundle_chan_t push,
  output logic                        full,
  input  wire logic                   pop,
  output tlex_pkg::bundle_chan_t      head
);

  localparam int PW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CW = $clog2(Depth + 1);

  tlex_pkg::bundle_t mem_r [Depth];
  logic [PW-1:0]     wr_ptr_r, rd_ptr_r;
  logic [CW-1:0]     count_r;
  logic              do_push, do_pop;

  assign full      = count_r == CW'(Depth);
  assign do_push   = push.valid && !full;
  assign do_pop    = pop && count_r != '0;
  assign head.valid = count_r != '0;
  assign head.data  = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push.data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == PW'(Depth - 1)) ? '0 : wr_ptr_r + PW'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PW'(Depth - 1)) ? '0 : rd_ptr_r + PW'(1);
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + CW'(1);
      end else if (do_pop && !do_push) begin
        count_r <= count_r - CW'(1);
      end
    end
  end

endmodule
`default_nettype wire

// ===== sv/tlex_back.sv =====
// tlex_back: walks the head bundle and hands out one result beat per cycle while out_stall is low
`default_nettype none
module tlex_back (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire tlex_pkg::bundle_chan_t head,
  output logic                        pop,
  output logic                        out_valid,
  input  wire logic                   out_stall,
  output logic [1:0]                  out_kind,
  output logic [7:0]                  out_text_char,
  output logic [4:0]                  out_token_type,
  output logic [7:0]                  out_token_length,
  output logic                        out_truncated,
  output logic                        out_last
);

  logic [1:0]     idx_r, idx_nxt;
  logic           fin;
  tlex_pkg::res_t cur;

  assign cur       = head.data.rec[idx_r];
  assign fin       = idx_r == head.data.cnt - 2'd1;
  assign out_valid = head.valid;
  assign pop       = head.valid && !out_stall && fin;

  assign out_kind         = cur.kind;
  assign out_text_char    = cur.text_char;
  assign out_token_type   = cur.token_type;
  assign out_token_length = cur.token_length;
  assign out_truncated    = cur.truncated;
  assign out_last         = fin;

  always_comb begin
    idx_nxt = idx_r;
    if (head.valid && !out_stall) begin
      idx_nxt = fin ? 2'd0 : idx_r + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r <= 2'd0;
    end else begin
      idx_r <= idx_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== sv/text_token_lexer.sv =====
// text_token_lexer: character-stream tokenizer, one character beat in, text and token beats out
// results: a beat's bundle is registered in the queue and read out after the bundles ahead of it
// throughput: one input beat per cycle while the queue is not full; the output side moves one result
//   beat per cycle while out_stall is low, each result of a bundle in turn; the queue absorbs bursts
// reset (synchronous, rst_n low): lexer idle, queue empty, max token length back to 255
`default_nettype none
module text_token_lexer #(
  parameter int FifoDepth = 4
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  // character beats
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [7:0] in_ch,
  input  wire logic       in_end_of_stream,
  // result beats
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic [1:0]      out_kind,
  output logic [7:0]      out_text_char,
  output logic [4:0]      out_token_type,
  output logic [7:0]      out_token_length,
  output logic            out_truncated,
  output logic            out_last,
  // max token length register
  input  wire logic       cfg_wr_en,
  input  wire logic [7:0] cfg_wr_data
);

  tlex_pkg::bundle_chan_t push;
  tlex_pkg::bundle_chan_t head;
  logic                   full;
  logic                   pop;
  logic                   accept;

  // the front only waits for room in the queue, never for the consumer directly
  assign in_stall = full;
  assign accept   = in_valid && !full;

  // front: classifies the character against the open token and builds up to
  // three result records (close of old token, text char, close of a one-char token or end of file)
  tlex_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .accept        (accept),
    .ch            (in_ch),
    .end_of_stream (in_end_of_stream),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data),
    .push          (push)
  );

  // bundles of results wait here so a stalled consumer does not block the front until the queue fills
  tlex_fifo #(
    .Depth (FifoDepth)
  ) u_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .full  (full),
    .pop   (pop),
    .head  (head)
  );

  // back: serializes the head bundle, flagging the last record of each beat
  tlex_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .head             (head),
    .pop              (pop),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_kind         (out_kind),
    .out_text_char    (out_text_char),
    .out_token_type   (out_token_type),
    .out_token_length (out_token_length),
    .out_truncated    (out_truncated),
    .out_last         (out_last)
  );

endmodule
`default_nettype wire

// ===== tb/sv/testbench.sv =====
// testbench: self-checking bench for the character-stream lexer under random stalls
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int HOLD_CYCLES   = 300;     // long receiver hold-off
  localparam int SETTLE_CYCLES = 8;       // quiet cycles before a limit write
  localparam int RANDOM_BEATS  = 80;      // random character beats, long token aside
  localparam int PHASES        = 8;
  localparam int MAX_REPORTS   = 10;

  // what the sender queue holds: a character beat, a limit write, or a drain pause
  typedef enum logic [1:0] {STIM_CHAR, STIM_SET_LIMIT, STIM_DRAIN} stim_op_t;
  typedef enum logic [1:0] {DRV_GAP, DRV_OFFER, DRV_DRAIN} drv_state_t;
  typedef enum logic [2:0] {CC_BLANK, CC_EOL, CC_DIGIT, CC_LETTER, CC_OTHER} char_class_t;

  typedef struct {
    stim_op_t   op;
    logic [7:0] ch;        // character, or the new limit
    logic       eos;
    int         gap_max;   // most idle cycles after this beat
  } stim_beat_t;

  typedef struct {
    tlex_pkg::res_t rec;
    logic           last;
  } lex_result_t;

  // clock, reset and block ports; the ones the bench drives are known from time zero
  logic       clk              = 1'b0;
  logic       rst_n            = 1'b0;
  logic       in_valid         = 1'b0;
  logic       in_stall;
  logic [7:0] in_ch            = 8'd0;
  logic       in_end_of_stream = 1'b0;
  logic       out_valid;
  logic       out_stall        = 1'b0;
  logic [1:0] out_kind;
  logic [7:0] out_text_char;
  logic [4:0] out_token_type;
  logic [7:0] out_token_length;
  logic       out_truncated;
  logic       out_last;
  logic       cfg_wr_en        = 1'b0;
  logic [7:0] cfg_wr_data      = 8'd0;

  text_token_lexer DUT (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_ch            (in_ch),
    .in_end_of_stream (in_end_of_stream),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_kind         (out_kind),
    .out_text_char    (out_text_char),
    .out_token_type   (out_token_type),
    .out_token_length (out_token_length),
    .out_truncated    (out_truncated),
    .out_last         (out_last),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_wr_data      (cfg_wr_data)
  );

  // 2 ns clock
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // lexer predictor: own copy of the token state and the length limit
  // ---------------------------------------------------------------------------
  tlex_pkg::mode_t tok_mode;
  logic            tok_point;       // number already holds its decimal point
  logic [7:0]      tok_count;       // text characters emitted for the open token
  logic [1:0]      tok_word;        // which keyword the identifier still matches
  logic            tok_over;        // open token lost text to the limit
  logic [7:0]      len_limit = tlex_pkg::MAX_LEN_RESET;
  tlex_pkg::res_t  beat_recs[$];    // results of the beat being predicted
  lex_result_t     expected_recs[$];

  function automatic char_class_t classify(input logic [7:0] c);
    if (c == " " || c == 8'h09 || c == 8'h0B || c == 8'h0C) return CC_BLANK;
    if (c == 8'h0A || c == 8'h0D) return CC_EOL;
    if (c >= "0" && c <= "9") return CC_DIGIT;
    if ((c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_") return CC_LETTER;
    return CC_OTHER;
  endfunction

  // single-character tokens; anything else maps to unknown
  function automatic logic [4:0] single_char_type(input logic [7:0] c);
    case (c)
      "=":      return tlex_pkg::TYPE_EQUAL;
      ":":      return tlex_pkg::TYPE_COLON;
      "@":      return tlex_pkg::TYPE_AT;
      ".":      return tlex_pkg::TYPE_DOT;
      ",":      return tlex_pkg::TYPE_COMMA;
      "!":      return tlex_pkg::TYPE_BANG;
      ";":      return tlex_pkg::TYPE_SEMI;
      "[":      return tlex_pkg::TYPE_LBRACK;
      "]":      return tlex_pkg::TYPE_RBRACK;
      "{":      return tlex_pkg::TYPE_LBRACE;
      "}":      return tlex_pkg::TYPE_RBRACE;
      "/", "\\": return tlex_pkg::TYPE_SLASH;
      "<":      return tlex_pkg::TYPE_LESS;
      ">":      return tlex_pkg::TYPE_GREATER;
      default:  return tlex_pkg::TYPE_UNKNOWN;
    endcase
  endfunction

  function automatic string word_text(input logic [1:0] w);
    return (w == tlex_pkg::KW_TRUE) ? "true" : "false";
  endfunction

  function automatic tlex_pkg::res_t make_rec(input logic [1:0] k, input logic [7:0] c,
                                              input logic [4:0] t, input logic [7:0] n,
                                              input logic tr);
    tlex_pkg::res_t r;
    r.kind         = k;
    r.text_char    = c;
    r.token_type   = t;
    r.token_length = n;
    r.truncated    = tr;
    return r;
  endfunction

  function automatic void lex_clear();
    tok_mode  = tlex_pkg::MODE_IDLE;
    tok_point = 1'b0;
    tok_count = 8'd0;
    tok_word  = tlex_pkg::KW_NONE;
    tok_over  = 1'b0;
  endfunction

  function automatic void lex_emit_char(input logic [7:0] c);
    if (tok_count < len_limit) begin
      beat_recs.push_back(make_rec(tlex_pkg::KIND_TEXT, c, tlex_pkg::TYPE_UNKNOWN, 8'd0,
                                   1'b0));
      tok_count++;
    end else begin
      tok_over = 1'b1;
    end
  endfunction

  function automatic void lex_close_token(input logic [4:0] t);
    beat_recs.push_back(make_rec(tlex_pkg::KIND_END, 8'd0, t, tok_count, tok_over));
    lex_clear();
  endfunction

  // a keyword only survives while every character was emitted and matches
  function automatic void lex_track_word(input logic [7:0] c);
    string w;
    if (tok_word == tlex_pkg::KW_NONE) return;
    w = word_text(tok_word);
    if (tok_over || tok_count >= len_limit || tok_count >= w.len() || w[tok_count] != c)
      tok_word = tlex_pkg::KW_NONE;
  endfunction

  function automatic logic [4:0] lex_word_type();
    string w;
    if (tok_word == tlex_pkg::KW_NONE || tok_over) return tlex_pkg::TYPE_IDENT;
    w = word_text(tok_word);
    return (tok_count == w.len()) ? tlex_pkg::TYPE_NUMBER : tlex_pkg::TYPE_IDENT;
  endfunction

  function automatic void lex_open_token(input logic [7:0] c);
    char_class_t cc;
    logic [4:0]  p;
    cc = classify(c);
    p  = single_char_type(c);
    if (cc == CC_BLANK || cc == CC_EOL) return;
    lex_clear();
    if (c == "\"") begin
      tok_mode = tlex_pkg::MODE_STRING;
    end else if (c == "?") begin
      lex_emit_char(c);
      tok_mode = tlex_pkg::MODE_HEADER;
    end else if (p != tlex_pkg::TYPE_UNKNOWN) begin
      lex_emit_char(c);
      lex_close_token(p);
    end else if (cc == CC_LETTER) begin
      tok_word = (c == "t") ? tlex_pkg::KW_TRUE :
                 (c == "f") ? tlex_pkg::KW_FALSE : tlex_pkg::KW_NONE;
      if (len_limit == 8'd0) tok_word = tlex_pkg::KW_NONE;
      lex_emit_char(c);
      tok_mode = tlex_pkg::MODE_IDENT;
    end else if (cc == CC_DIGIT) begin
      lex_emit_char(c);
      tok_mode = tlex_pkg::MODE_NUMBER;
    end else begin
      lex_emit_char(c);
      lex_close_token(tlex_pkg::TYPE_UNKNOWN);
    end
  endfunction

  // works out every result of one accepted beat and queues them in order
  function automatic void lex_predict_beat(input logic [7:0] c, input logic eos);
    char_class_t cc;
    lex_result_t e;
    cc = classify(c);
    beat_recs.delete();
    if (eos) begin
      case (tok_mode)
        tlex_pkg::MODE_IDENT:  lex_close_token(lex_word_type());
        tlex_pkg::MODE_HEADER: lex_close_token(tlex_pkg::TYPE_HEADER);
        tlex_pkg::MODE_NUMBER: lex_close_token(tlex_pkg::TYPE_NUMBER);
        tlex_pkg::MODE_STRING: lex_close_token(tlex_pkg::TYPE_INVALID);
        default:               lex_clear();
      endcase
      beat_recs.push_back(make_rec(tlex_pkg::KIND_EOF, 8'd0, tlex_pkg::TYPE_EOF, 8'd0, 1'b0));
    end else begin
      case (tok_mode)
        tlex_pkg::MODE_IDENT: begin
          if (cc == CC_LETTER || cc == CC_DIGIT) begin
            lex_track_word(c);
            lex_emit_char(c);
          end else begin
            lex_close_token(lex_word_type());
            lex_open_token(c);
          end
        end
        tlex_pkg::MODE_HEADER: begin
          if (cc == CC_LETTER || cc == CC_DIGIT) begin
            lex_emit_char(c);
          end else begin
            lex_close_token(tlex_pkg::TYPE_HEADER);
            lex_open_token(c);
          end
        end
        tlex_pkg::MODE_NUMBER: begin
          if (cc == CC_DIGIT || (c == "." && !tok_point)) begin
            if (c == ".") tok_point = 1'b1;
            lex_emit_char(c);
          end else begin
            lex_close_token(tlex_pkg::TYPE_NUMBER);
            lex_open_token(c);
          end
        end
        tlex_pkg::MODE_STRING: begin
          if (c == "\"") lex_close_token(tlex_pkg::TYPE_STRING);
          else if (cc == CC_EOL) lex_close_token(tlex_pkg::TYPE_INVALID);
          else lex_emit_char(c);
        end
        default: lex_open_token(c);
      endcase
    end
    foreach (beat_recs[i]) begin
      e.rec  = beat_recs[i];
      e.last = (i == beat_recs.size() - 1);
      expected_recs.push_back(e);
    end
  endfunction

  // ---------------------------------------------------------------------------
  // stimulus building
  // ---------------------------------------------------------------------------
  stim_beat_t stim_q[$];
  int         phase_gap = 8;
  int         queued_beats = 0;
  string      letter_set = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ_";
  string      digit_set  = "0123456789";
  string      punct_set  = "=:@.,!;[]{}/\\<>";

  function automatic logic [7:0] alnum_char();
    int i;
    i = $urandom_range(0, 62);
    return (i < 53) ? letter_set[i] : digit_set[i - 53];
  endfunction

  // any byte that keeps a string open
  function automatic logic [7:0] string_char();
    logic [7:0] c;
    c = 8'($urandom_range(0, 255));
    while (c == "\"" || c == 8'h0A || c == 8'h0D) c = 8'($urandom_range(0, 255));
    return c;
  endfunction

  function automatic logic [7:0] blank_char(input int i);
    case (i)
      0:       return " ";
      1:       return 8'h09;
      2:       return 8'h0B;
      3:       return 8'h0C;
      4:       return 8'h0D;
      default: return 8'h0A;
    endcase
  endfunction

  task automatic push_entry(input stim_op_t op, input logic [7:0] c, input logic eos);
    stim_beat_t b;
    b.op      = op;
    b.ch      = c;
    b.eos     = eos;
    b.gap_max = phase_gap;
    stim_q.push_back(b);
    if (op == STIM_CHAR) queued_beats++;
  endtask

  task automatic push_char(input logic [7:0] c);
    push_entry(STIM_CHAR, c, 1'b0);
  endtask

  task automatic push_text(input string s);
    foreach (s[i]) push_char(s[i]);
  endtask

  // end of stream carries a random, ignored character
  task automatic push_eos();
    push_entry(STIM_CHAR, 8'($urandom_range(0, 255)), 1'b1);
  endtask

  task automatic push_limit(input logic [7:0] v);
    push_entry(STIM_SET_LIMIT, v, 1'b0);
  endtask

  // one token of random content, mostly well formed, with some noise
  task automatic add_random_token();
    int pick;
    int n;
    pick = $urandom_range(0, 39);
    if (pick < 8) begin
      push_char(letter_set[$urandom_range(0, 52)]);
      n = $urandom_range(0, 9);
      repeat (n) push_char(alnum_char());
    end else if (pick < 12) begin
      // keywords and near misses
      case ($urandom_range(0, 5))
        0:       push_text("true");
        1:       push_text("false");
        2:       push_text("tru");
        3:       push_text("falsey");
        4:       push_text("t");
        default: push_text("fa1se");
      endcase
    end else if (pick < 16) begin
      push_char("?");
      n = $urandom_range(0, 5);
      repeat (n) push_char(alnum_char());
    end else if (pick < 22) begin
      n = $urandom_range(1, 4);
      repeat (n) push_char(digit_set[$urandom_range(0, 9)]);
      if ($urandom_range(0, 1) == 1) begin
        push_char(".");
        n = $urandom_range(0, 3);
        repeat (n) push_char(digit_set[$urandom_range(0, 9)]);
        if ($urandom_range(0, 3) == 0) push_char(".");
      end
    end else if (pick < 28) begin
      push_char("\"");
      n = $urandom_range(0, 7);
      repeat (n) push_char(string_char());
      case ($urandom_range(0, 9))
        0:       push_char(8'h0A);
        1:       push_char(8'h0D);
        default: push_char("\"");
      endcase
    end else if (pick < 35) begin
      push_char(punct_set[$urandom_range(0, punct_set.len() - 1)]);
    end else if (pick < 38) begin
      push_char(8'($urandom_range(0, 255)));
    end else begin
      push_eos();
    end
    if ($urandom_range(0, 1) == 1) push_char(blank_char($urandom_range(0, 5)));
  endtask

  // ---------------------------------------------------------------------------
  // character driver: pops the queue, idles at random, pauses for drain entries and limit writes
  // ---------------------------------------------------------------------------
  drv_state_t drv_state = DRV_GAP;
  int         gap_left = 0;
  int         cur_gap_max = 0;
  int         settle_cnt = 0;
  int         beats_sent = 0;
  stim_beat_t held;
  logic       stim_done = 1'b0;
  int         pending_cnt = 0;      // results still owed, as of the last edge

  always @(posedge clk) begin : char_driver
    logic       valid_n;
    logic       eos_n;
    logic       wr_n;
    logic       try_pop;
    logic [7:0] ch_n;
    logic [7:0] wr_data_n;
    stim_beat_t nxt;
    if (!rst_n) begin
      drv_state = DRV_GAP;
      gap_left  = 0;
      in_valid  <= 1'b0;
      cfg_wr_en <= 1'b0;
    end else begin
      valid_n   = in_valid;
      ch_n      = in_ch;
      eos_n     = in_end_of_stream;
      wr_n      = 1'b0;
      wr_data_n = cfg_wr_data;
      try_pop   = 1'b0;
      case (drv_state)
        DRV_GAP: begin
          if (gap_left != 0) gap_left--;
          try_pop = (gap_left == 0);
        end
        DRV_OFFER: begin
          // beat taken: draw this beat's idle time, or offer the next at once
          if (in_valid && !in_stall) begin
            valid_n = 1'b0;
            beats_sent++;
            gap_left = $urandom_range(0, cur_gap_max);
            if (gap_left == 0) try_pop = 1'b1;
            else drv_state = DRV_GAP;
          end
        end
        default: begin
          // wait until every result is out and the block has gone quiet
          if (pending_cnt == 0 && !out_valid) settle_cnt++;
          else settle_cnt = 0;
          if (settle_cnt >= SETTLE_CYCLES) begin
            if (held.op == STIM_SET_LIMIT) begin
              wr_n      = 1'b1;
              wr_data_n = held.ch;
            end
            // go back through the gap state so no beat lands on the write edge
            drv_state = DRV_GAP;
            gap_left  = 1;
          end
        end
      endcase
      if (try_pop) begin
        if (stim_q.size() == 0) begin
          stim_done <= 1'b1;
          drv_state = DRV_GAP;
        end else begin
          nxt = stim_q.pop_front();
          if (nxt.op == STIM_CHAR) begin
            valid_n     = 1'b1;
            ch_n        = nxt.ch;
            eos_n       = nxt.eos;
            cur_gap_max = nxt.gap_max;
            drv_state   = DRV_OFFER;
          end else begin
            held       = nxt;
            settle_cnt = 0;
            drv_state  = DRV_DRAIN;
          end
        end
      end
      in_valid         <= valid_n;
      in_ch            <= ch_n;
      in_end_of_stream <= eos_n;
      cfg_wr_en        <= wr_n;
      cfg_wr_data      <= wr_data_n;
    end
  end

  // ---------------------------------------------------------------------------
  // result sink: random stall per beat, stall-free stretches, long hold-offs
  // ---------------------------------------------------------------------------
  int stall_left = 0;
  int hold_left  = 0;
  int sink_beats = 0;
  int holds_done = 0;

  always @(posedge clk) begin : result_sink
    logic stall_n;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      stall_n = 1'b0;
      if (hold_left != 0) begin
        hold_left--;
        stall_n = (hold_left != 0);
      end else if (out_valid && !out_stall) begin
        sink_beats++;
        if (sink_beats % 400 == 150) begin
          // long hold-off so the block backs up into its input
          hold_left = HOLD_CYCLES;
          stall_n   = 1'b1;
          holds_done++;
        end else begin
          stall_left = ((sink_beats / 100) % 3 == 1) ? 0 : $urandom_range(0, 8);
          stall_n    = (stall_left != 0);
        end
      end else if (stall_left != 0) begin
        stall_left--;
        stall_n = (stall_left != 0);
      end
      out_stall <= stall_n;
    end
  end

  // ---------------------------------------------------------------------------
  // monitor: predicts accepted beats, checks result beats against the queue
  // ---------------------------------------------------------------------------
  int fail_cnt = 0;
  int results_checked = 0;
  int cut_tokens = 0;
  int eof_seen = 0;
  int limit_writes = 0;

  always @(posedge clk) begin : result_monitor
    lex_result_t    want;
    tlex_pkg::res_t got;
    if (!rst_n) begin
      len_limit = tlex_pkg::MAX_LEN_RESET;
      lex_clear();
      expected_recs.delete();
      pending_cnt <= 0;
    end else begin
      // limit write and beat on the same edge never happen, write first anyway
      if (cfg_wr_en) begin
        len_limit = cfg_wr_data;
        limit_writes++;
      end
      if (in_valid && !in_stall) lex_predict_beat(in_ch, in_end_of_stream);
      if (out_valid && !out_stall) begin
        got = make_rec(out_kind, out_text_char, out_token_type, out_token_length,
                       out_truncated);
        if (expected_recs.size() == 0) begin
          fail_cnt++;
          if (fail_cnt <= MAX_REPORTS)
            $display("%0t: stray result kind %0d char %02h type %0d len %0d cut %0b last %0b",
                     $time, got.kind, got.text_char, got.token_type, got.token_length,
                     got.truncated, out_last);
        end else begin
          want = expected_recs.pop_front();
          results_checked++;
          if (want.rec.kind == tlex_pkg::KIND_END && want.rec.truncated) cut_tokens++;
          if (want.rec.kind == tlex_pkg::KIND_EOF) eof_seen++;
          if (got.kind !== want.rec.kind || got.text_char !== want.rec.text_char ||
              got.token_type !== want.rec.token_type ||
              got.token_length !== want.rec.token_length ||
              got.truncated !== want.rec.truncated || out_last !== want.last) begin
            fail_cnt++;
            if (fail_cnt <= MAX_REPORTS) begin
              $display("%0t: mismatch exp kind %0d char %02h type %0d len %0d cut %0b last %0b",
                       $time, want.rec.kind, want.rec.text_char, want.rec.token_type,
                       want.rec.token_length, want.rec.truncated, want.last);
              $display("%0t: mismatch got kind %0d char %02h type %0d len %0d cut %0b last %0b",
                       $time, got.kind, got.text_char, got.token_type, got.token_length,
                       got.truncated, out_last);
            end
          end
        end
      end
      pending_cnt <= expected_recs.size();
    end
  end

  // ---------------------------------------------------------------------------
  // run control
  // ---------------------------------------------------------------------------
  initial begin : run_control
    int limit_plan [PHASES];
    int base;
    int waited;
    int left_over;
    limit_plan = '{4, 255, 1, 5, 0, 2, 3, 128};

    // directed, reset limit of 255: keywords, header with digits, number with a
    // second point, string cut by a line end, byte extremes, end of stream
    phase_gap = 8;
    push_text("true false?k9.5..");
    push_char("\"");
    push_char("q");
    push_char(8'h0D);
    push_char(8'hFF);
    push_char(8'h00);
    push_eos();
    // zero limit: no text at all, every token with text is cut
    push_limit(8'd0);
    push_text("ab1 ?");
    push_eos();
    // limit of one: closed string cut short, then a string open at end of stream
    push_limit(8'd1);
    push_text("\"xy\"\"z");
    push_eos();

    // random phases, each under its own limit and idling style
    for (int p = 0; p < PHASES; p++) begin
      push_limit(8'(limit_plan[p]));
      phase_gap = (p % 3 == 0) ? 0 : 8;
      if (p == PHASES - 1) begin
        // one identifier well past this phase's limit
        push_char("x");
        repeat (limit_plan[p] + 1) push_char(alnum_char());
        push_char(" ");
      end
      base = queued_beats;
      while (queued_beats - base < RANDOM_BEATS / PHASES) begin
        add_random_token();
        // sender pause midway on odd phases, block left mid-stream
        if (p % 2 == 1 && queued_beats - base >= RANDOM_BEATS / (2 * PHASES) &&
            stim_q[stim_q.size() - 1].op == STIM_CHAR &&
            queued_beats - base < RANDOM_BEATS / (2 * PHASES) + 3)
          push_entry(STIM_DRAIN, 8'd0, 1'b0);
      end
      push_eos();
    end

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    wait (stim_done);
    waited = 0;
    while (pending_cnt != 0 && waited < 50000) begin
      @(posedge clk);
      waited++;
    end
    repeat (16) @(posedge clk);
    left_over = pending_cnt;
    if (left_over != 0) $display("%0d expected result beats never arrived", left_over);

    $display("covered %0d character beats, %0d result beats checked, %0d limit writes",
             beats_sent, results_checked, limit_writes);
    $display("covered %0d cut tokens, %0d end-of-file records, %0d long output hold-offs",
             cut_tokens, eof_seen, holds_done);
    if (fail_cnt == 0 && left_over == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // hard limit on run time, far above the slowest correct run
  initial begin : watchdog
    #1000000;
    $display("Verification failed");
    $finish;
  end

endmodule

// ===== text_token_lexer.f =====
sv/tlex_pkg.sv
sv/tlex_front.sv
sv/tlex_fifo.sv
sv/tlex_back.sv
sv/text_token_lexer.sv
tb/sv/testbench.sv
